### rtl/hbta_pkg.sv
// ============================================================================
// hbta_pkg
// Shared types and constants for the heap block table allocator.
// ============================================================================
`default_nettype none
package hbta_pkg;
    localparam int MAX_BLOCKS = 256;
    localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);

    localparam logic [31:0] PAGE_LOW_MASK  = 32'h0000_0FFF;
    localparam logic [31:0] PAGE_HIGH_MASK = 32'hFFFF_F000;
    localparam logic [31:0] PAGE_BYTES     = 32'h0000_1000;

    localparam logic [1:0] FN_ALLOC   = 2'd0;
    localparam logic [1:0] FN_ALLOC_A = 2'd1;
    localparam logic [1:0] FN_FREE    = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] request_size;
        logic [31:0] block_address;
    } req_t;

    typedef struct packed {
        logic [31:0]      result_address;
        logic [1:0]       status;
        logic [CNT_W-1:0] entry_count;
        logic [31:0]      bytes_in_use;
    } rsp_t;

    // token travelling along the cell row
    typedef struct packed {
        logic        valid;
        logic [31:0] cand;
        logic [31:0] size;
    } tok_t;

    // control broadcast from the sequencer to every cell
    typedef struct packed {
        logic        push;     // shift table one place toward the tail
        logic        remove;   // close gap at the matching cell
        logic [31:0] new_base;
        logic [31:0] new_size;
        logic [31:0] match_addr;
    } ctl_t;
endpackage
`default_nettype wire

### rtl/hbta_if.sv
// ============================================================================
// hbta_req_if / hbta_rsp_if
// Valid/ready channels for request and result items.
// ============================================================================
`default_nettype none
interface hbta_req_if;
    logic          valid;
    logic          ready;
    hbta_pkg::req_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface hbta_rsp_if;
    logic          valid;
    logic          ready;
    hbta_pkg::rsp_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

### rtl/hbta_cell.sv
// ============================================================================
// hbta_cell
// One table slot: holds a block, bumps the passing candidate past it.
// ============================================================================
`default_nettype none
module hbta_cell (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire hbta_pkg::ctl_t ctl,
    input  wire logic          live,       // slot index below entry count
    input  wire logic          prev_match, // some newer slot matched
    input  wire logic [31:0]   prev_base,  // newer neighbor
    input  wire logic [31:0]   prev_size,
    input  wire logic          is_head,
    input  wire logic [31:0]   next_base,  // older neighbor
    input  wire logic [31:0]   next_size,
    input  wire hbta_pkg::tok_t tok_in,    // from older neighbor
    output hbta_pkg::tok_t     tok_out,
    output logic [31:0]        base,
    output logic [31:0]        size,
    output logic               match_out
);
    import hbta_pkg::*;

    logic [31:0] base_reg;
    logic [31:0] size_reg;
    tok_t        tok_reg;
    tok_t        tok_next;
    logic [31:0] e1;
    logic [31:0] e2;
    logic        ovl;
    logic        hit;

    assign e1  = base_reg + size_reg;
    assign e2  = tok_in.cand + tok_in.size;
    assign ovl = ((base_reg >= tok_in.cand) && (base_reg < e2)) ||
                 ((tok_in.cand >= base_reg) && (tok_in.cand < e1));

    always_comb
    begin
        tok_next = tok_in;
        if (tok_in.valid && live && ovl)
        begin
            tok_next.cand = e1;
        end
    end

    assign hit       = live && (base_reg == ctl.match_addr);
    assign match_out = prev_match || hit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.push)
        begin
            base_reg <= is_head ? ctl.new_base : prev_base;
            size_reg <= is_head ? ctl.new_size : prev_size;
        end
        else if (ctl.remove && match_out)
        begin
            base_reg <= next_base;
            size_reg <= next_size;
        end
    end

    assign tok_out = tok_reg;
    assign base    = base_reg;
    assign size    = size_reg;
endmodule
`default_nettype wire

### rtl/hbta_row.sv
// ============================================================================
// hbta_row
// Chain of table cells; candidate flows from tail (oldest) to head.
// ============================================================================
`default_nettype none
module hbta_row (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire hbta_pkg::ctl_t              ctl,
    input  wire logic [hbta_pkg::CNT_W-1:0]  count,
    input  wire hbta_pkg::tok_t              tok_in,
    output hbta_pkg::tok_t                   tok_out,
    output logic                             found,
    output logic [31:0]                      found_size
);
    import hbta_pkg::*;

    tok_t        tok  [MAX_BLOCKS+1];
    logic [31:0] b    [MAX_BLOCKS+1];
    logic [31:0] s    [MAX_BLOCKS+1];
    logic        m    [MAX_BLOCKS+1];
    logic [31:0] hsel [MAX_BLOCKS+1];

    assign tok[MAX_BLOCKS] = tok_in;
    assign b[MAX_BLOCKS]   = '0;
    assign s[MAX_BLOCKS]   = '0;

    genvar g;
    generate
        for (g = 0; g < MAX_BLOCKS; g++)
        begin : g_cell
            logic live;
            logic pm;
            assign live = (CNT_W'(g) < count);
            if (g == 0)
            begin : g_h
                assign pm = 1'b0;
            end
            else
            begin : g_t
                assign pm = m[g-1];
            end
            hbta_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctl        (ctl),
                .live       (live),
                .prev_match (pm),
                .prev_base  (g == 0 ? 32'd0 : b[(g == 0) ? 0 : g-1]),
                .prev_size  (g == 0 ? 32'd0 : s[(g == 0) ? 0 : g-1]),
                .is_head    (g == 0),
                .next_base  (b[g+1]),
                .next_size  (s[g+1]),
                .tok_in     (tok[g+1]),
                .tok_out    (tok[g]),
                .base       (b[g]),
                .size       (s[g]),
                .match_out  (m[g])
            );
            // size of first matching slot
            assign hsel[g] = (m[g] && !pm) ? s[g] : 32'd0;
        end
    endgenerate

    always_comb
    begin
        found_size = '0;
        for (int i = 0; i < MAX_BLOCKS; i++)
        begin
            found_size = found_size | hsel[i];
        end
    end

    assign hsel[MAX_BLOCKS] = '0;
    assign m[MAX_BLOCKS]    = 1'b0;
    assign found   = m[MAX_BLOCKS-1] | m[MAX_BLOCKS] | (|hsel[MAX_BLOCKS]);
    assign tok_out = tok[0];
endmodule
`default_nettype wire

### rtl/heap_block_table_allocator.sv
// ============================================================================
// heap_block_table_allocator
// Block table allocator: overlap walk through a chain of table cells.
// ============================================================================
//  channel  dir  payload
//  req      in   func, request_size, block_address
//  rsp      out  result_address, status, entry_count, bytes_in_use
//  cfg      in   heap_start (cfg_we, cfg_wdata)
//
//  Allocate, table full included: the candidate walks the row, one cell per
//  cycle, before the result is formed; free and unused codes do not wait for
//  the walk. One item in flight.
//  Reset clears count, total and control; table contents need no clear.
//  A held result stalls the next acceptance only until it is taken.
`default_nettype none
module heap_block_table_allocator (
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   cfg_we,
    input  wire logic [31:0] cfg_wdata,
    hbta_req_if.sink    req,
    hbta_rsp_if.source  rsp
);
    import hbta_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_WALK = 4'b0010,
        S_DONE = 4'b0100,
        S_OUT  = 4'b1000
    } state_t;

    localparam int WALK_W = $clog2(MAX_BLOCKS + 2);

    state_t            state_reg, state_next;
    logic [31:0]       heap_start_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [31:0]       total_reg;
    req_t              req_reg;
    logic [WALK_W-1:0] walk_reg;
    rsp_t              rsp_reg;
    rsp_t              rsp_next;
    logic              rsp_valid_reg;
    logic [31:0]       cand_reg;
    ctl_t              ctl;
    tok_t              tin;
    tok_t              tout;
    logic              found;
    logic [31:0]       found_size;
    logic [31:0]       cand_al;
    logic              is_alloc;

    assign is_alloc = (req_reg.func == FN_ALLOC) || (req_reg.func == FN_ALLOC_A);

    assign tin.valid = (state_reg == S_IDLE) && req.valid && !rsp_valid_reg &&
                       ((req.data.func == FN_ALLOC) || (req.data.func == FN_ALLOC_A));
    assign tin.cand  = heap_start_reg;
    assign tin.size  = req.data.request_size;

    assign cand_al = ((req_reg.func == FN_ALLOC_A) && ((cand_reg & PAGE_LOW_MASK) != 0))
                   ? ((cand_reg & PAGE_HIGH_MASK) + PAGE_BYTES) : cand_reg;

    always_comb
    begin
        ctl.push       = 1'b0;
        ctl.remove     = 1'b0;
        ctl.new_base   = cand_al;
        ctl.new_size   = req_reg.request_size;
        ctl.match_addr = req_reg.block_address;
        if (state_reg == S_DONE)
        begin
            if (is_alloc && (count_reg != CNT_W'(MAX_BLOCKS)))
            begin
                ctl.push = 1'b1;
            end
            else if ((req_reg.func == FN_FREE) && (req_reg.block_address != 32'd0))
            begin
                ctl.remove = 1'b1;
            end
        end
    end

    hbta_row u_row (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .count      (count_reg),
        .tok_in     (tin),
        .tok_out    (tout),
        .found      (found),
        .found_size (found_size)
    );

    assign req.ready = (state_reg == S_IDLE) && !rsp_valid_reg;
    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (req.valid && req.ready) state_next = S_WALK;
            S_WALK: if (!is_alloc || (walk_reg == WALK_W'(MAX_BLOCKS))) state_next = S_DONE;
            S_DONE: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        rsp_next.result_address = 32'd0;
        rsp_next.status         = ST_OK;
        rsp_next.entry_count    = count_reg;
        rsp_next.bytes_in_use   = total_reg;
        if (is_alloc)
        begin
            if (ctl.push)
            begin
                rsp_next.result_address = cand_al;
                rsp_next.entry_count    = count_reg + 1'b1;
                rsp_next.bytes_in_use   = total_reg + req_reg.request_size;
            end
            else
            begin
                rsp_next.status = ST_FULL;
            end
        end
        else if (req_reg.func == FN_FREE)
        begin
            if (ctl.remove && found)
            begin
                rsp_next.result_address = req_reg.block_address;
                rsp_next.entry_count    = count_reg - 1'b1;
                rsp_next.bytes_in_use   = total_reg - found_size;
            end
            else
            begin
                rsp_next.status = ST_NOT_FOUND;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            heap_start_reg <= '0;
            count_reg      <= '0;
            total_reg      <= '0;
            walk_reg       <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                heap_start_reg <= cfg_wdata;
            end
            if (rsp.valid && rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
            if (state_reg == S_IDLE)
            begin
                walk_reg <= '0;
            end
            else if (state_reg == S_WALK)
            begin
                walk_reg <= walk_reg + 1'b1;
            end
            if (state_reg == S_DONE)
            begin
                rsp_valid_reg <= 1'b1;
                if (ctl.push)
                begin
                    count_reg <= count_reg + 1'b1;
                    total_reg <= total_reg + req_reg.request_size;
                end
                else if (ctl.remove && found)
                begin
                    count_reg <= count_reg - 1'b1;
                    total_reg <= total_reg - found_size;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            req_reg <= req.data;
        end
        if (tout.valid)
        begin
            cand_reg <= tout.cand;
        end
        if (state_reg == S_DONE)
        begin
            rsp_reg <= rsp_next;
        end
    end
endmodule
`default_nettype wire

### tb/sv/tb_top.sv
// ============================================================================
// tb_top
// Self-checking bench for heap_block_table_allocator: a directed table, then
// random allocate/free phases under several heap starts. Every result item is
// compared field by field with an in-bench block table predictor or typed row.
// ============================================================================
`default_nettype none
module tb_top;
    import hbta_pkg::*;

    localparam logic [1:0] FN_UNUSED   = 2'd3;
    localparam int         CYCLE_LIMIT = 3_000_000;
    localparam int         DRAIN_WAIT  = MAX_BLOCKS + 40;

    typedef struct {
        logic [1:0]  func;
        logic [31:0] size;
        logic [31:0] addr;
        bit          typed;
        rsp_t        rsp;
    } dir_row_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [31:0] cfg_wdata;

    hbta_req_if req_ch ();
    hbta_rsp_if rsp_ch ();

    heap_block_table_allocator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    // predictor state
    logic [31:0] tbl_base [MAX_BLOCKS];
    logic [31:0] tbl_size [MAX_BLOCKS];
    int unsigned tbl_count;
    logic [31:0] tbl_total;
    logic [31:0] heap_base;

    rsp_t pending_rsp [$];
    int   mismatches;
    int   cycles;
    bit   sink_no_stall;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("heap_block_table_allocator verification failed");
            $finish;
        end
    end

    function automatic bit blocks_overlap(logic [31:0] b1, logic [31:0] s1,
                                          logic [31:0] b2, logic [31:0] s2);
        logic [31:0] e1;
        logic [31:0] e2;
        e1 = b1 + s1;
        e2 = b2 + s2;
        return (b1 >= b2 && b1 < e2) || (b2 >= b1 && b2 < e1);
    endfunction

    function automatic rsp_t heap_table_step(req_t r);
        rsp_t        o;
        logic [31:0] cand;
        int          hit;
        o.result_address = '0;
        o.status         = ST_OK;
        if (r.func == FN_ALLOC || r.func == FN_ALLOC_A)
        begin
            if (tbl_count >= MAX_BLOCKS)
                o.status = ST_FULL;
            else
            begin
                cand = heap_base;
                for (int k = int'(tbl_count) - 1; k >= 0; k--)
                    if (blocks_overlap(tbl_base[k], tbl_size[k], cand, r.request_size))
                        cand = tbl_base[k] + tbl_size[k];
                if (r.func == FN_ALLOC_A && (cand & PAGE_LOW_MASK) != 0)
                    cand = (cand & PAGE_HIGH_MASK) + PAGE_BYTES;
                for (int k = int'(tbl_count); k > 0; k--)
                begin
                    tbl_base[k] = tbl_base[k-1];
                    tbl_size[k] = tbl_size[k-1];
                end
                tbl_base[0] = cand;
                tbl_size[0] = r.request_size;
                tbl_count++;
                tbl_total += r.request_size;
                o.result_address = cand;
            end
        end
        else if (r.func == FN_FREE)
        begin
            o.status = ST_NOT_FOUND;
            hit = -1;
            if (r.block_address != 0)
                for (int k = 0; k < int'(tbl_count); k++)
                    if (hit < 0 && tbl_base[k] == r.block_address)
                        hit = k;
            if (hit >= 0)
            begin
                tbl_total -= tbl_size[hit];
                for (int k = hit; k + 1 < int'(tbl_count); k++)
                begin
                    tbl_base[k] = tbl_base[k+1];
                    tbl_size[k] = tbl_size[k+1];
                end
                tbl_count--;
                o.status = ST_OK;
                o.result_address = r.block_address;
            end
        end
        o.entry_count  = tbl_count[CNT_W-1:0];
        o.bytes_in_use = tbl_total;
        return o;
    endfunction

    // result sink: check, then draw a stall for the next item unless stalls are off
    int stall_left;
    always @(posedge clk or negedge rst_n)
    begin
        rsp_t exp_rsp;
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            stall_left   <= 0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (pending_rsp.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result item %p", rsp_ch.data);
                end
                else
                begin
                    exp_rsp = pending_rsp.pop_front();
                    if (rsp_ch.data.result_address !== exp_rsp.result_address ||
                        rsp_ch.data.status !== exp_rsp.status ||
                        rsp_ch.data.entry_count !== exp_rsp.entry_count ||
                        rsp_ch.data.bytes_in_use !== exp_rsp.bytes_in_use)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result mismatch: expected %p actual %p",
                                     exp_rsp, rsp_ch.data);
                    end
                end
                if (sink_no_stall)
                begin
                    rsp_ch.ready <= 1'b1;
                    stall_left   <= 0;
                end
                else
                begin
                    stall_left   <= $urandom_range(0, 5);
                    rsp_ch.ready <= 1'b0;
                end
            end
            else if (stall_left > 0)
            begin
                stall_left   <= stall_left - 1;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    task automatic send_item(req_t r, bit typed, rsp_t typed_rsp, int gap);
        rsp_t p;
        req_ch.valid <= 1'b1;
        req_ch.data  <= r;
        do
            @(posedge clk);
        while (!req_ch.ready);
        p = heap_table_step(r);
        pending_rsp.push_back(typed ? typed_rsp : p);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic write_heap_start(logic [31:0] v);
        req_ch.valid <= 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        heap_base = v;
    endtask

    function automatic logic [31:0] rand_size();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 10)
            return '0;
        else if (pick < 20)
            return $urandom();
        else if (pick < 40)
            return 32'($urandom_range(1, 4)) << 12;
        else
            return 32'($urandom_range(1, 32'h3000));
    endfunction

    function automatic req_t rand_item(int alloc_pct);
        req_t        r;
        int unsigned pick;
        r.request_size  = rand_size();
        r.block_address = $urandom();
        pick = $urandom_range(0, 99);
        if (pick < 2)
            r.func = FN_UNUSED;
        else if (pick < 2 + alloc_pct)
            r.func = $urandom_range(0, 1) ? FN_ALLOC_A : FN_ALLOC;
        else
        begin
            r.func = FN_FREE;
            pick = $urandom_range(0, 99);
            if (pick < 5)
                r.block_address = '0;
            else if (pick < 85 && tbl_count > 0)
                r.block_address = tbl_base[$urandom_range(0, tbl_count - 1)];
        end
        return r;
    endfunction

    dir_row_t    dir_rows [$];
    logic [31:0] phase_heap [8] = '{32'h0000_1000, 32'h0000_0000, 32'hFFFF_F000,
                                    32'h0000_0FFF, 32'hFFFF_FFFF, 32'h8000_0000,
                                    32'h1234_5678, 32'h0001_0000};
    int          phase_len  [8] = '{100, 340, 120, 100, 100, 130, 120, 120};
    int          phase_pct  [8] = '{55, 96, 20, 60, 55, 50, 70, 30};

    initial
    begin
        rsp_t zr;
        req_t r;
        int   gap;
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_wdata    = '0;
        req_ch.valid = 1'b0;
        req_ch.data  = '0;
        sink_no_stall = 1'b0;
        tbl_count    = 0;
        tbl_total    = '0;
        heap_base    = '0;
        zr           = '0;

        dir_rows = '{
            '{FN_FREE,   32'h0,         32'h0,         1, '{32'h0, ST_NOT_FOUND, 9'd0, 32'h0}},
            '{FN_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, '{32'h0, ST_OK, 9'd0, 32'h0}},
            '{FN_FREE,   32'h0,         32'h1234,      1, '{32'h0, ST_NOT_FOUND, 9'd0, 32'h0}},
            '{FN_ALLOC,  32'h10,        32'h0,         1, '{32'h0, ST_OK, 9'd1, 32'h10}},
            '{FN_ALLOC,  32'h10,        32'h0,         0, zr},
            '{FN_ALLOC_A, 32'h100,      32'h0,         0, zr},
            '{FN_ALLOC,  32'h0,         32'h0,         0, zr},
            '{FN_ALLOC_A, 32'h1,        32'h0,         0, zr},
            '{FN_ALLOC,  32'hFFFF_FFFF, 32'h0,         0, zr},
            '{FN_FREE,   32'hFFFF_FFFF, 32'h10,        0, zr},
            '{FN_FREE,   32'h0,         32'h0,         1, '{32'h0, ST_NOT_FOUND, 9'd5,
                                                               32'h0000_0110}},
            '{FN_FREE,   32'h0,         32'hFFFF_FFFF, 0, zr},
            '{FN_ALLOC,  32'h8000_0000, 32'h0,         0, zr},
            '{FN_ALLOC_A, 32'h1000,     32'h0,         0, zr},
            '{FN_UNUSED, 32'h0,         32'h0,         0, zr},
            '{FN_FREE,   32'h0,         32'h0000_1000, 0, zr},
            '{FN_FREE,   32'h0,         32'h10,        0, zr},
            '{FN_ALLOC,  32'h20,        32'h0,         0, zr}
        };

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        write_heap_start(32'h0);
        foreach (dir_rows[i])
        begin
            r.func          = dir_rows[i].func;
            r.request_size  = dir_rows[i].size;
            r.block_address = dir_rows[i].addr;
            send_item(r, dir_rows[i].typed, dir_rows[i].rsp, $urandom_range(0, 1));
        end

        for (int ph = 0; ph < 8; ph++)
        begin
            write_heap_start(ph == 5 ? 32'($urandom()) : phase_heap[ph]);
            sink_no_stall = (ph == 3);
            for (int n = 0; n < phase_len[ph]; n++)
            begin
                r   = rand_item(phase_pct[ph]);
                gap = (ph == 3 || ph == 6) ? 0 : $urandom_range(0, 5);
                send_item(r, 1'b0, zr, gap);
            end
        end
        req_ch.valid <= 1'b0;

        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (mismatches == 0 && pending_rsp.size() == 0)
            $display("heap_block_table_allocator verification clean");
        else
            $display("heap_block_table_allocator verification failed");
        $finish;
    end
endmodule
`default_nettype wire
